FILE: hw/rtl/sps_pkg.sv
// Shared types and codes for the shortest path search block.
`timescale 1ns / 1ps
`default_nettype none
package sps_pkg;

  localparam int NODE_W  = 4;
  localparam int VIS_N   = 1 << NODE_W;
  localparam int ECOST_W = 16;
  localparam int PCOST_W = 20;
  localparam logic [PCOST_W-1:0] PATH_MAX_COST = '1;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_UNREACHABLE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_POP_RD, S_POP_TOP, S_POP_LAST, S_SD_L, S_SD_LR, S_SD_R, S_SD_CMP,
    S_EVAL, S_SCAN, S_EDGE, S_SU, S_SU_CMP
  } state_t;

  typedef struct packed {
    logic [NODE_W-1:0]  from;
    logic [NODE_W-1:0]  to;
    logic [ECOST_W-1:0] cost;
  } edge_t;

  typedef struct packed {
    logic [PCOST_W-1:0] cost;
    logic [NODE_W-1:0]  node;
  } heap_ent_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sps_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sps_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 24,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/shortest_path_search_top.sv
// Top level: edge table, binary min-heap and the Dijkstra query sequencer.
// Clear, append and unused requests: result registered one cycle after the transfer.
// Query: about 1 + pops * (5 + 4 * log2(heap)) + expanded nodes * (1 + 2 * edges)
//   + pushes * (1 + 2 * log2(heap)) cycles, set by the single heap RAM port; one item at a time.
// Reset (rst, synchronous, active high) empties the edge table and the heap and drops
//   any pending result; both RAMs need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module shortest_path_search_top #(
  parameter int NODE_COUNT = 16,
  parameter int MAX_EDGES  = 64,
  parameter int COST_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [3:0]  edge_from,
  input  wire logic [3:0]  edge_to,
  input  wire logic [15:0] edge_cost,
  input  wire logic [3:0]  query_source,
  input  wire logic [3:0]  query_target,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [19:0]      path_cost
);

  localparam int HEAP_DEPTH = MAX_EDGES + 1;
  localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EC_W = $clog2(MAX_EDGES + 1);
  localparam int HA_W = $clog2(HEAP_DEPTH);
  localparam int HS_W = $clog2(HEAP_DEPTH + 1);
  localparam int LW   = HA_W + 2;  // child index arithmetic
  localparam logic [sps_pkg::ECOST_W-1:0] COST_MASK =
    (COST_BITS >= sps_pkg::ECOST_W) ? '1 : sps_pkg::ECOST_W'((1 << COST_BITS) - 1);

  // Edge table RAM.
  logic                 e_we;
  logic [EA_W-1:0]      e_waddr, e_raddr;
  sps_pkg::edge_t       e_wdata, e_rdata;

  sps_ram #(.DEPTH(MAX_EDGES), .WIDTH($bits(sps_pkg::edge_t)), .AW(EA_W)) u_edge_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  // Frontier heap RAM.
  logic                 h_we;
  logic [HA_W-1:0]      h_waddr, h_raddr;
  sps_pkg::heap_ent_t   h_wdata, h_rdata;

  sps_ram #(.DEPTH(HEAP_DEPTH), .WIDTH($bits(sps_pkg::heap_ent_t)), .AW(HA_W)) u_heap_ram (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  sps_pkg::state_t state, state_next;
  logic [EC_W-1:0]  edge_count, edge_count_next;
  logic [EC_W-1:0]  k, k_next;
  logic [HS_W-1:0]  hsize, hsize_next;
  logic [HA_W-1:0]  idx, idx_next;        // sift position
  logic [HA_W-1:0]  cidx, cidx_next;      // chosen child
  sps_pkg::heap_ent_t cur, cur_next;      // popped entry
  sps_pkg::heap_ent_t last, last_next;    // entry moved down on pop
  sps_pkg::heap_ent_t child, child_next;
  sps_pkg::heap_ent_t ins, ins_next;      // entry being pushed
  logic [sps_pkg::NODE_W-1:0] dst, dst_next;
  logic [sps_pkg::VIS_N-1:0]  visited, visited_next;
  logic             out_valid_next;
  logic [1:0]       status_next;
  logic [19:0]      path_cost_next;

  logic             accept;
  logic [LW-1:0]    lidx, ridx, hsize_w;
  logic [HA_W-1:0]  pidx;
  logic [sps_pkg::PCOST_W:0] sum;
  logic             edge_hit;

  assign in_stall = (state != sps_pkg::S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  assign lidx    = {1'b0, idx, 1'b1};
  assign ridx    = lidx + LW'(1);
  assign hsize_w = LW'(hsize);
  assign pidx    = HA_W'((idx - HA_W'(1)) >> 1);
  assign sum     = {1'b0, cur.cost} + (sps_pkg::PCOST_W + 1)'(e_rdata.cost);
  assign edge_hit = (e_rdata.from == cur.node) && (32'(e_rdata.to) < NODE_COUNT)
                    && !visited[e_rdata.to];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sps_pkg::S_IDLE;
      edge_count <= '0;
      hsize      <= '0;
      out_valid  <= 1'b0;
      visited    <= '0;
    end else begin
      state      <= state_next;
      edge_count <= edge_count_next;
      hsize      <= hsize_next;
      out_valid  <= out_valid_next;
      visited    <= visited_next;
    end
  end

  always_ff @(posedge clk) begin
    k         <= k_next;
    idx       <= idx_next;
    cidx      <= cidx_next;
    cur       <= cur_next;
    last      <= last_next;
    child     <= child_next;
    ins       <= ins_next;
    dst       <= dst_next;
    status    <= status_next;
    path_cost <= path_cost_next;
  end

  always_comb begin
    state_next      = state;
    edge_count_next = edge_count;
    k_next          = k;
    hsize_next      = hsize;
    idx_next        = idx;
    cidx_next       = cidx;
    cur_next        = cur;
    last_next       = last;
    child_next      = child;
    ins_next        = ins;
    dst_next        = dst;
    visited_next    = visited;
    out_valid_next  = out_valid && out_stall;
    status_next     = status;
    path_cost_next  = path_cost;
    e_we    = 1'b0;
    e_waddr = edge_count[EA_W-1:0];
    e_wdata = '{from: edge_from, to: edge_to, cost: edge_cost & COST_MASK};
    e_raddr = k[EA_W-1:0];
    h_we    = 1'b0;
    h_waddr = idx;
    h_wdata = last;
    h_raddr = '0;

    unique case (state)
      sps_pkg::S_IDLE: begin
        if (accept) begin
          out_valid_next = 1'b1;
          status_next    = sps_pkg::ST_OK;
          path_cost_next = '0;
          unique case (sps_pkg::req_t'(req_type))
            sps_pkg::REQ_CLEAR: edge_count_next = '0;
            sps_pkg::REQ_APPEND: begin
              if (32'(edge_count) >= MAX_EDGES) begin
                status_next = sps_pkg::ST_FULL;
              end else begin
                e_we = 1'b1;
                edge_count_next = edge_count + EC_W'(1);
              end
            end
            sps_pkg::REQ_QUERY: begin
              visited_next = '0;
              if (32'(query_source) >= NODE_COUNT || 32'(query_target) >= NODE_COUNT) begin
                status_next = sps_pkg::ST_UNREACHABLE;
              end else begin
                // Seed the heap with the source at cost zero.
                out_valid_next = 1'b0;
                dst_next   = query_target;
                h_we       = 1'b1;
                h_waddr    = '0;
                h_wdata    = '{cost: '0, node: query_source};
                hsize_next = HS_W'(1);
                state_next = sps_pkg::S_POP_RD;
              end
            end
            default: ;
          endcase
        end
      end
      sps_pkg::S_POP_RD: begin
        h_raddr    = '0;
        state_next = sps_pkg::S_POP_TOP;
      end
      sps_pkg::S_POP_TOP: begin
        cur_next   = h_rdata;
        hsize_next = hsize - HS_W'(1);
        h_raddr    = HA_W'(hsize - HS_W'(1));
        state_next = (hsize == HS_W'(1)) ? sps_pkg::S_EVAL : sps_pkg::S_POP_LAST;
      end
      sps_pkg::S_POP_LAST: begin
        last_next  = h_rdata;
        idx_next   = '0;
        state_next = sps_pkg::S_SD_L;
      end
      sps_pkg::S_SD_L: begin
        if (lidx >= hsize_w) begin
          h_we       = 1'b1;
          state_next = sps_pkg::S_EVAL;
        end else begin
          h_raddr    = HA_W'(lidx);
          state_next = sps_pkg::S_SD_LR;
        end
      end
      sps_pkg::S_SD_LR: begin
        child_next = h_rdata;
        cidx_next  = HA_W'(lidx);
        if (ridx < hsize_w) begin
          h_raddr    = HA_W'(ridx);
          state_next = sps_pkg::S_SD_R;
        end else begin
          state_next = sps_pkg::S_SD_CMP;
        end
      end
      sps_pkg::S_SD_R: begin
        if (h_rdata.cost < child.cost) begin
          child_next = h_rdata;
          cidx_next  = HA_W'(ridx);
        end
        state_next = sps_pkg::S_SD_CMP;
      end
      sps_pkg::S_SD_CMP: begin
        h_we = 1'b1;
        if (child.cost >= last.cost) begin
          state_next = sps_pkg::S_EVAL;
        end else begin
          h_wdata    = child;
          idx_next   = cidx;
          state_next = sps_pkg::S_SD_L;
        end
      end
      sps_pkg::S_EVAL: begin
        if (32'(cur.node) >= NODE_COUNT || visited[cur.node]) begin
          if (hsize == '0) begin
            out_valid_next = 1'b1;
            status_next    = sps_pkg::ST_UNREACHABLE;
            state_next     = sps_pkg::S_IDLE;
          end else begin
            state_next = sps_pkg::S_POP_RD;
          end
        end else begin
          visited_next[cur.node] = 1'b1;
          if (cur.node == dst) begin
            out_valid_next = 1'b1;
            path_cost_next = cur.cost;
            state_next     = sps_pkg::S_IDLE;
          end else begin
            k_next     = '0;
            state_next = sps_pkg::S_SCAN;
          end
        end
      end
      sps_pkg::S_SCAN: begin
        if (k >= edge_count) begin
          if (hsize == '0) begin
            out_valid_next = 1'b1;
            status_next    = sps_pkg::ST_UNREACHABLE;
            state_next     = sps_pkg::S_IDLE;
          end else begin
            state_next = sps_pkg::S_POP_RD;
          end
        end else begin
          state_next = sps_pkg::S_EDGE;
        end
      end
      sps_pkg::S_EDGE: begin
        k_next     = k + EC_W'(1);
        state_next = sps_pkg::S_SCAN;
        if (edge_hit && 32'(hsize) < HEAP_DEPTH) begin
          ins_next.cost = sum[sps_pkg::PCOST_W] ? sps_pkg::PATH_MAX_COST
                                                : sum[sps_pkg::PCOST_W-1:0];
          ins_next.node = e_rdata.to;
          idx_next   = HA_W'(hsize);
          hsize_next = hsize + HS_W'(1);
          state_next = sps_pkg::S_SU;
        end
      end
      sps_pkg::S_SU: begin
        h_raddr = pidx;
        if (idx == '0) begin
          h_we       = 1'b1;
          h_wdata    = ins;
          state_next = sps_pkg::S_SCAN;
        end else begin
          state_next = sps_pkg::S_SU_CMP;
        end
      end
      sps_pkg::S_SU_CMP: begin
        h_we = 1'b1;
        if (h_rdata.cost <= ins.cost) begin
          h_wdata    = ins;
          state_next = sps_pkg::S_SCAN;
        end else begin
          h_wdata    = h_rdata;
          idx_next   = pidx;
          state_next = sps_pkg::S_SU;
        end
      end
      default: state_next = sps_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sps_checker.sv
// Port-level checks for the shortest path search block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sps_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  req_type,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  status,
  input wire logic [19:0] path_cost
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(path_cost))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= 2'(sps_pkg::ST_UNREACHABLE))
    else $error("status code out of range");

  a_cost_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != sps_pkg::ST_OK |-> path_cost == '0)
    else $error("nonzero cost on failed request");

  a_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && req_type != sps_pkg::REQ_QUERY |=> out_valid)
    else $error("edit result not delivered next cycle");

endmodule

bind shortest_path_search_top sps_checker u_sps_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
  .out_valid(out_valid), .out_stall(out_stall), .status(status), .path_cost(path_cost)
);
`default_nettype wire
